>>> rtl/core/light_gate_speed_trap_unit_assert.svh
// assertion macros of the light gate speed trap port checker
`ifndef LIGHT_GATE_SPEED_TRAP_UNIT_ASSERT_SVH
`define LIGHT_GATE_SPEED_TRAP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LGST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define LGST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/lgst_pkg.sv
// types and constants of the light gate speed trap
package lgst_pkg;

	// data path widths
	localparam int DIST_W  = 16;
	localparam int LIMIT_W = 8;
	localparam int BLOCK_W = 8;
	localparam int SPEED_W = 16;
	localparam int COUNT_W = 16;
	localparam int TIME_W  = 32;
	localparam int DIV_W   = 32;
	localparam int LIM100_W = 15;
	localparam int PROD_W  = LIM100_W + TIME_W;
	localparam int CFG_IDX_W = 2;

	// statistics stop counting at this many passes
	localparam logic [COUNT_W-1:0] MAX_PASSES = 16'd65535;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GATE_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SECONDS = 2'd2;

	// configuration reset values
	localparam logic [DIST_W-1:0]   RST_GATE_DISTANCE = 16'd100;
	localparam logic [LIMIT_W-1:0]  RST_SPEED_LIMIT   = 8'd2;
	localparam logic [BLOCK_W-1:0]  RST_BLOCK_SECONDS = 8'd10;
	localparam logic [LIM100_W-1:0] CM_PER_M          = 15'd100;

	// result kinds
	typedef enum logic [2:0] {
		K_OK        = 3'd0,
		K_SPEEDING  = 3'd1,
		K_TOO_FAST  = 3'd2,
		K_WRONG_WAY = 3'd3,
		K_BLOCKING  = 3'd4,
		K_REPORT    = 3'd5
	} kind_t;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/core/light_gate_speed_trap_unit.sv
// Two-beam light gate speed trap. Each input word is a beam sample or an end of session
// request; a word yields at most one result word, always marked last. A beam sample that
// ends no timed pass goes through the accept and evaluate steps; a pass with zero travel seconds
// adds a final step; a timed pass and a report with passes also wait for the shared
// 32-step serial divider that computes both the pass speed and the session average. A new
// word is accepted while the previous result still waits in the output register; a word
// that has a result of its own holds at its final step until that register is free.
// The configuration port is always ready.
module light_gate_speed_trap_unit
	import lgst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input words
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic                 beam1_lit,
	input  logic                 beam2_lit,
	input  logic                 second_tick,
	// result words
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           kind,
	output logic [SPEED_W-1:0]   speed_cms,
	output logic [TIME_W-1:0]    travel_seconds,
	output logic [COUNT_W-1:0]   pass_count,
	output logic [COUNT_W-1:0]   speeder_count,
	output logic [SPEED_W-1:0]   max_speed_cms,
	output logic [SPEED_W-1:0]   min_speed_cms,
	output logic [SPEED_W-1:0]   avg_speed_cms,
	output logic                 stats_valid,
	output logic                 last,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIST_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		G_IDLE    = 3'd0,
		G_MOVE_R  = 3'd1,
		G_MOVE_L  = 3'd2,
		G_EXIT_B1 = 3'd3,
		G_EXIT_B2 = 3'd4,
		G_HOLD_B1 = 3'd5,
		G_HOLD_B2 = 3'd6
	} gate_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_EVAL,
		C_DIV,
		C_FIN
	} ctl_t;

	typedef struct packed {
		kind_t              kind;
		logic [SPEED_W-1:0] speed;
		logic [TIME_W-1:0]  travel;
		logic [COUNT_W-1:0] passes;
		logic [COUNT_W-1:0] speeders;
		logic [SPEED_W-1:0] max_speed;
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] avg_speed;
		logic               stats_valid;
		logic               last;
	} res_t;

	function automatic res_t mk_res(
		input kind_t              k,
		input logic [SPEED_W-1:0] spd,
		input logic [TIME_W-1:0]  trv,
		input logic [COUNT_W-1:0] pc,
		input logic [COUNT_W-1:0] sc,
		input logic [SPEED_W-1:0] mx,
		input logic [SPEED_W-1:0] mn,
		input logic [SPEED_W-1:0] avg,
		input logic               sv
	);
		res_t r;
		r.kind        = k;
		r.speed       = spd;
		r.travel      = trv;
		r.passes      = pc;
		r.speeders    = sc;
		r.max_speed   = mx;
		r.min_speed   = mn;
		r.avg_speed   = avg;
		r.stats_valid = sv;
		r.last        = 1'b1;
		return r;
	endfunction

	// configuration
	logic [DIST_W-1:0]   dist_q;
	logic [LIM100_W-1:0] lim100_q;
	logic [BLOCK_W-1:0]  block_q;

	// sequencer and item
	ctl_t ctl_q;
	logic func_q;
	logic b1_q;
	logic b2_q;

	// gate and session state
	gate_t              gate_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  entry_q;
	logic [TIME_W-1:0]  hall_q;
	logic               fresh_q;
	logic               warn_q;
	logic [COUNT_W-1:0] passes_q;
	logic [COUNT_W-1:0] speeders_q;
	logic [SPEED_W-1:0] fastest_q;
	logic [SPEED_W-1:0] slowest_q;
	logic [TIME_W-1:0]  sum_q;

	// pass timing
	logic [TIME_W-1:0] travel_q;
	logic [PROD_W-1:0] prod_q;
	logic              op_avg_q;

	// divider link and output register
	div_req_t div_req_q;
	div_rsp_t div_rsp;
	res_t     out_q;
	logic     out_valid_q;

	logic               out_free;
	logic               accept;
	logic [TIME_W-1:0]  hall_start_c;
	logic               blk_c;
	logic [TIME_W-1:0]  travel_c;
	logic               exit_lit_c;
	logic               hold_lit_c;
	logic               need_out_c;
	logic [SPEED_W-1:0] fin_speed_c;
	logic               fin_fast_c;
	kind_t              fin_kind_c;
	logic               stat_upd_c;
	logic [COUNT_W-1:0] passes_n;
	logic [COUNT_W-1:0] speeders_n;

	lgst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (ctl_q == C_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// blocking check, hall time counts from the first moving sample
	assign hall_start_c = fresh_q ? now_q : hall_q;
	assign blk_c = !warn_q && ((now_q - hall_start_c) > {{(TIME_W-BLOCK_W){1'b0}}, block_q});

	// beam tests of the waiting states
	assign travel_c   = now_q - entry_q;
	assign exit_lit_c = (gate_q == G_EXIT_B1) ? b1_q : b2_q;
	assign hold_lit_c = (gate_q == G_HOLD_B1) ? b1_q : b2_q;

	// evaluate step has a result of its own
	always_comb begin
		need_out_c = 1'b0;
		if (func_q) begin
			need_out_c = (passes_q == '0);
		end else begin
			case (gate_q)
				G_MOVE_R, G_MOVE_L: need_out_c = blk_c;
				G_HOLD_B1, G_HOLD_B2: need_out_c = hold_lit_c && !fresh_q;
				default: need_out_c = 1'b0;
			endcase
		end
	end

	// pass judgement and statistics update
	assign fin_speed_c = (travel_q == '0) ? '0 : div_rsp.quotient[SPEED_W-1:0];
	assign fin_fast_c  = (travel_q != '0) &&
		({{(PROD_W-DIST_W){1'b0}}, dist_q} > prod_q);
	assign fin_kind_c  = (travel_q == '0) ? K_TOO_FAST : (fin_fast_c ? K_SPEEDING : K_OK);
	assign stat_upd_c  = passes_q < MAX_PASSES;
	assign passes_n    = stat_upd_c ? passes_q + 1'b1 : passes_q;
	assign speeders_n  = (stat_upd_c && fin_fast_c) ? speeders_q + 1'b1 : speeders_q;

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q      <= RST_GATE_DISTANCE;
			lim100_q    <= {{(LIM100_W-LIMIT_W){1'b0}}, RST_SPEED_LIMIT} * CM_PER_M;
			block_q     <= RST_BLOCK_SECONDS;
			ctl_q       <= C_IDLE;
			func_q      <= 1'b0;
			b1_q        <= 1'b1;
			b2_q        <= 1'b1;
			gate_q      <= G_IDLE;
			now_q       <= '0;
			entry_q     <= '0;
			hall_q      <= '0;
			fresh_q     <= 1'b0;
			warn_q      <= 1'b1;
			passes_q    <= '0;
			speeders_q  <= '0;
			fastest_q   <= '0;
			slowest_q   <= '1;
			sum_q       <= '0;
			travel_q    <= '0;
			prod_q      <= '0;
			op_avg_q    <= 1'b0;
			div_req_q   <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// configuration writes
			if (cfg_valid) begin
				case (cfg_index)
					REG_GATE_DISTANCE: dist_q <= cfg_data;
					REG_SPEED_LIMIT: begin
						lim100_q <= {{(LIM100_W-LIMIT_W){1'b0}}, cfg_data[LIMIT_W-1:0]} * CM_PER_M;
					end
					REG_BLOCK_SECONDS: block_q <= cfg_data[BLOCK_W-1:0];
					default: ;
				endcase
			end

			case (ctl_q)
				// take a word, the seconds tick counts first
				C_IDLE: begin
					if (accept) begin
						func_q <= func;
						b1_q   <= beam1_lit;
						b2_q   <= beam2_lit;
						now_q  <= now_q + {{(TIME_W-1){1'b0}}, second_tick};
						ctl_q  <= C_EVAL;
					end
				end

				// judge the word against the gate state
				C_EVAL: begin
					if (!(need_out_c && !out_free)) begin
						ctl_q <= C_IDLE;
						if (func_q) begin
							if (passes_q != '0) begin
								op_avg_q           <= 1'b1;
								div_req_q.start    <= 1'b1;
								div_req_q.dividend <= sum_q;
								div_req_q.divisor  <= {{(DIV_W-COUNT_W){1'b0}}, passes_q};
								ctl_q              <= C_DIV;
							end else begin
								out_valid_q <= 1'b1;
								out_q <= mk_res(K_REPORT, '0, '0, passes_q, speeders_q,
									'0, '0, '0, 1'b0);
								gate_q     <= G_IDLE;
								entry_q    <= '0;
								hall_q     <= '0;
								fresh_q    <= 1'b0;
								warn_q     <= 1'b1;
								passes_q   <= '0;
								speeders_q <= '0;
								fastest_q  <= '0;
								slowest_q  <= '1;
								sum_q      <= '0;
							end
						end else begin
							case (gate_q)
								G_MOVE_R, G_MOVE_L: begin
									if (fresh_q) begin
										hall_q  <= now_q;
										fresh_q <= 1'b0;
									end
									if (blk_c) begin
										warn_q      <= 1'b1;
										out_valid_q <= 1'b1;
										out_q <= mk_res(K_BLOCKING, '0, '0, passes_q,
											speeders_q, '0, '0, '0, 1'b0);
									end
									if (!b1_q) begin
										gate_q <= (gate_q == G_MOVE_L) ? G_EXIT_B1 : G_HOLD_B1;
									end else if (!b2_q) begin
										gate_q <= (gate_q == G_MOVE_R) ? G_EXIT_B2 : G_HOLD_B2;
									end
								end
								G_EXIT_B1, G_EXIT_B2: begin
									if (exit_lit_c) begin
										travel_q <= travel_c;
										op_avg_q <= 1'b0;
										prod_q   <= {{(PROD_W-LIM100_W){1'b0}}, lim100_q} *
											{{(PROD_W-TIME_W){1'b0}}, travel_c};
										if (travel_c != '0) begin
											div_req_q.start    <= 1'b1;
											div_req_q.dividend <= {{(DIV_W-DIST_W){1'b0}}, dist_q};
											div_req_q.divisor  <= travel_c;
											ctl_q              <= C_DIV;
										end else begin
											ctl_q <= C_FIN;
										end
									end
								end
								G_HOLD_B1, G_HOLD_B2: begin
									if (hold_lit_c) begin
										if (fresh_q) begin
											entry_q <= now_q;
											gate_q  <= (gate_q == G_HOLD_B1) ? G_MOVE_R : G_MOVE_L;
										end else begin
											gate_q      <= G_IDLE;
											out_valid_q <= 1'b1;
											out_q <= mk_res(K_WRONG_WAY, '0, '0, passes_q,
												speeders_q, '0, '0, '0, 1'b0);
										end
									end
								end
								default: begin
									// idle, beam1 wins when both are broken
									gate_q <= G_IDLE;
									if (!b1_q) begin
										gate_q  <= G_HOLD_B1;
										fresh_q <= 1'b1;
									end else if (!b2_q) begin
										gate_q  <= G_HOLD_B2;
										fresh_q <= 1'b1;
									end
								end
							endcase
						end
					end
				end

				// wait for the divider
				C_DIV: begin
					if (div_rsp.done) begin
						ctl_q <= C_FIN;
					end
				end

				// close the pass or the report
				C_FIN: begin
					if (out_free) begin
						ctl_q       <= C_IDLE;
						out_valid_q <= 1'b1;
						if (op_avg_q) begin
							out_q <= mk_res(K_REPORT, '0, '0, passes_q, speeders_q, fastest_q,
								slowest_q, div_rsp.quotient[SPEED_W-1:0], 1'b1);
							gate_q     <= G_IDLE;
							entry_q    <= '0;
							hall_q     <= '0;
							fresh_q    <= 1'b0;
							warn_q     <= 1'b1;
							passes_q   <= '0;
							speeders_q <= '0;
							fastest_q  <= '0;
							slowest_q  <= '1;
							sum_q      <= '0;
						end else begin
							out_q <= mk_res(fin_kind_c, fin_speed_c, travel_q, passes_n,
								speeders_n, '0, '0, '0, 1'b0);
							if (stat_upd_c) begin
								if (fin_speed_c > fastest_q) begin
									fastest_q <= fin_speed_c;
								end
								if (fin_speed_c < slowest_q) begin
									slowest_q <= fin_speed_c;
								end
								sum_q <= sum_q + {{(TIME_W-SPEED_W){1'b0}}, fin_speed_c};
							end
							passes_q   <= passes_n;
							speeders_q <= speeders_n;
							warn_q     <= 1'b0;
							gate_q     <= G_IDLE;
						end
					end
				end

				default: ctl_q <= C_IDLE;
			endcase
		end
	end

	// result ports
	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign speed_cms      = out_q.speed;
	assign travel_seconds = out_q.travel;
	assign pass_count     = out_q.passes;
	assign speeder_count  = out_q.speeders;
	assign max_speed_cms  = out_q.max_speed;
	assign min_speed_cms  = out_q.min_speed;
	assign avg_speed_cms  = out_q.avg_speed;
	assign stats_valid    = out_q.stats_valid;
	assign last           = out_q.last;

endmodule

>>> rtl/core/lgst_div.sv
// shared restoring divider, one quotient bit per cycle
module lgst_div
	import lgst_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, dvs_q};

	// step sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!trial[DIV_W]) begin
					rem_q <= trial[DIV_W-1:0];
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/core/lgst_checker.sv
// port checker of the light gate speed trap and its bind
`include "light_gate_speed_trap_unit_assert.svh"

module lgst_checker
	import lgst_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [2:0]           kind,
	input logic [SPEED_W-1:0]   speed_cms,
	input logic [TIME_W-1:0]    travel_seconds,
	input logic [COUNT_W-1:0]   pass_count,
	input logic [SPEED_W-1:0]   max_speed_cms,
	input logic [SPEED_W-1:0]   min_speed_cms,
	input logic [SPEED_W-1:0]   avg_speed_cms,
	input logic                 stats_valid,
	input logic                 last
);

	// a stalled result word holds
	`LGST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(speed_cms) && $stable(travel_seconds) && $stable(pass_count), "result word changed while stalled")

	// every result word carries last, as one word in gives at most one result out
	`LGST_ASSERT_SAME(a_last_set, out_valid, last, "result word without last")

	// statistics fields only in a report
	`LGST_ASSERT_SAME(a_stats_report, out_valid && kind != K_REPORT, !stats_valid && avg_speed_cms == '0 && max_speed_cms == '0 && min_speed_cms == '0, "statistics outside a report")

	// average lies between least and greatest speed
	`LGST_ASSERT_SAME(a_avg_range, out_valid && stats_valid, kind == K_REPORT && min_speed_cms <= avg_speed_cms && avg_speed_cms <= max_speed_cms, "report average out of range")

	// the unit is busy right after taking a word
	`LGST_ASSERT_NEXT(a_busy_after, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule

bind light_gate_speed_trap_unit lgst_checker u_lgst_checker (.*);

>>> dv/light_gate_speed_trap_unit_checker.sv
// checker for the light gate speed trap: tracks the gate, predicts result words, compares them
`timescale 1ns / 100ps

module light_gate_speed_trap_unit_checker
	import lgst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 func,
	input  logic                 beam1_lit,
	input  logic                 beam2_lit,
	input  logic                 second_tick,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [2:0]           kind,
	input  logic [SPEED_W-1:0]   speed_cms,
	input  logic [TIME_W-1:0]    travel_seconds,
	input  logic [COUNT_W-1:0]   pass_count,
	input  logic [COUNT_W-1:0]   speeder_count,
	input  logic [SPEED_W-1:0]   max_speed_cms,
	input  logic [SPEED_W-1:0]   min_speed_cms,
	input  logic [SPEED_W-1:0]   avg_speed_cms,
	input  logic                 stats_valid,
	input  logic                 last,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIST_W-1:0]    cfg_data,
	output int                   errors,
	output int                   pending
);

	// where the walker is in the gate
	typedef enum logic [2:0] {
		GS_IDLE    = 3'd0,
		GS_MOVE_R  = 3'd1,
		GS_MOVE_L  = 3'd2,
		GS_EXIT_B1 = 3'd3,
		GS_EXIT_B2 = 3'd4,
		GS_HOLD_B1 = 3'd5,
		GS_HOLD_B2 = 3'd6
	} gate_state_e;

	typedef struct {
		kind_t        kind;
		logic [15:0]  speed;
		logic [31:0]  travel;
		logic [15:0]  passes;
		logic [15:0]  speeders;
		logic [15:0]  fastest;
		logic [15:0]  slowest;
		logic [15:0]  mean;
		logic         valid;
		logic         last;
	} trap_result_t;

	trap_result_t due_results[$];
	trap_result_t head;

	// register copies
	logic [15:0] dist_cfg;
	logic [7:0]  limit_cfg;
	logic [7:0]  block_cfg;

	// gate and session state
	gate_state_e gstate;
	logic [31:0] clock_s;
	logic [31:0] entry_s;
	logic [31:0] hall_start;
	logic        fresh;
	logic        warned;
	logic [15:0] pass_tally;
	logic [15:0] speeder_tally;
	logic [15:0] fastest;
	logic [15:0] slowest;
	logic [31:0] speed_sum;

	function automatic void restart_session();
		gstate        = GS_IDLE;
		entry_s       = '0;
		hall_start    = '0;
		fresh         = 1'b0;
		warned        = 1'b1;
		pass_tally    = '0;
		speeder_tally = '0;
		fastest       = '0;
		slowest       = 16'hFFFF;
		speed_sum     = '0;
	endfunction

	// counts are taken as they stand when the word is formed
	function automatic void queue_result(kind_t k, logic [15:0] spd, logic [31:0] trv,
			logic [15:0] mx, logic [15:0] mn, logic [15:0] avg, logic ok);
		trap_result_t r;
		r.kind     = k;
		r.speed    = spd;
		r.travel   = trv;
		r.passes   = pass_tally;
		r.speeders = speeder_tally;
		r.fastest  = mx;
		r.slowest  = mn;
		r.mean     = avg;
		r.valid    = ok;
		r.last     = 1'b0;
		due_results.push_back(r);
	endfunction

	// one input word through the gate
	function automatic void judge_word(logic rep, logic b1, logic b2, logic tick);
		int          first;
		logic [31:0] trv;
		logic [31:0] spd;
		logic [31:0] avg;
		logic [63:0] bound;
		logic        fast;
		kind_t       k;
		first = due_results.size();
		if (tick)
			clock_s++;
		if (rep) begin
			if (pass_tally != 0) begin
				avg = speed_sum / {16'd0, pass_tally};
				queue_result(K_REPORT, '0, '0, fastest, slowest, avg[15:0], 1'b1);
			end else begin
				queue_result(K_REPORT, '0, '0, '0, '0, '0, 1'b0);
			end
			restart_session();
		end else begin
			case (gstate)
				GS_MOVE_R, GS_MOVE_L: begin
					if (fresh) begin
						hall_start = clock_s;
						fresh = 1'b0;
					end
					if (!warned && (clock_s - hall_start) > {24'd0, block_cfg}) begin
						queue_result(K_BLOCKING, '0, '0, '0, '0, '0, 1'b0);
						warned = 1'b1;
					end
					// beam1 wins when both are broken
					if (!b1)
						gstate = (gstate == GS_MOVE_L) ? GS_EXIT_B1 : GS_HOLD_B1;
					else if (!b2)
						gstate = (gstate == GS_MOVE_R) ? GS_EXIT_B2 : GS_HOLD_B2;
				end
				GS_EXIT_B1, GS_EXIT_B2: begin
					if ((gstate == GS_EXIT_B1) ? b1 : b2) begin
						trv  = clock_s - entry_s;
						spd  = '0;
						fast = 1'b0;
						k    = K_TOO_FAST;
						if (trv != 0) begin
							spd   = {16'd0, dist_cfg} / trv;
							bound = {56'd0, limit_cfg} * 64'd100 * {32'd0, trv};
							fast  = {48'd0, dist_cfg} > bound;
							k     = fast ? K_SPEEDING : K_OK;
						end
						// statistics freeze once full
						if (pass_tally < MAX_PASSES) begin
							pass_tally++;
							if (fast)
								speeder_tally++;
							if (spd > {16'd0, fastest})
								fastest = spd[15:0];
							if (spd < {16'd0, slowest})
								slowest = spd[15:0];
							speed_sum += spd;
						end
						warned = 1'b0;
						gstate = GS_IDLE;
						queue_result(k, spd[15:0], trv, '0, '0, '0, 1'b0);
					end
				end
				GS_HOLD_B1, GS_HOLD_B2: begin
					if ((gstate == GS_HOLD_B1) ? b1 : b2) begin
						if (fresh) begin
							entry_s = clock_s;
							gstate = (gstate == GS_HOLD_B1) ? GS_MOVE_R : GS_MOVE_L;
						end else begin
							gstate = GS_IDLE;
							queue_result(K_WRONG_WAY, '0, '0, '0, '0, '0, 1'b0);
						end
					end
				end
				default: begin
					gstate = GS_IDLE;
					if (!b1) begin
						gstate = GS_HOLD_B1;
						fresh = 1'b1;
					end else if (!b2) begin
						gstate = GS_HOLD_B2;
						fresh = 1'b1;
					end
				end
			endcase
		end
		if (due_results.size() > first)
			due_results[due_results.size() - 1].last = 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// result words first, then register writes, then the new input word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_cfg  = RST_GATE_DISTANCE;
			limit_cfg = RST_SPEED_LIMIT;
			block_cfg = RST_BLOCK_SECONDS;
			clock_s   = '0;
			restart_session();
			due_results.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result word of kind %0d with none expected", kind);
					errors++;
				end else begin
					head = due_results.pop_front();
					check_field("kind", 32'(head.kind), 32'(kind));
					check_field("speed_cms", 32'(head.speed), 32'(speed_cms));
					check_field("travel_seconds", head.travel, travel_seconds);
					check_field("pass_count", 32'(head.passes), 32'(pass_count));
					check_field("speeder_count", 32'(head.speeders), 32'(speeder_count));
					check_field("max_speed_cms", 32'(head.fastest), 32'(max_speed_cms));
					check_field("min_speed_cms", 32'(head.slowest), 32'(min_speed_cms));
					check_field("avg_speed_cms", 32'(head.mean), 32'(avg_speed_cms));
					check_field("stats_valid", 32'(head.valid), 32'(stats_valid));
					check_field("last", 32'(head.last), 32'(last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GATE_DISTANCE: dist_cfg  = cfg_data;
					REG_SPEED_LIMIT:   limit_cfg = cfg_data[7:0];
					REG_BLOCK_SECONDS: block_cfg = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				judge_word(func, beam1_lit, beam2_lit, second_tick);
		end
		pending = due_results.size();
	end

endmodule

>>> dv/light_gate_speed_trap_unit_tb.sv
// testbench top for the light gate speed trap: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module light_gate_speed_trap_unit_tb;
	import lgst_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 func;
	logic                 beam1_lit;
	logic                 beam2_lit;
	logic                 second_tick;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           kind;
	logic [SPEED_W-1:0]   speed_cms;
	logic [TIME_W-1:0]    travel_seconds;
	logic [COUNT_W-1:0]   pass_count;
	logic [COUNT_W-1:0]   speeder_count;
	logic [SPEED_W-1:0]   max_speed_cms;
	logic [SPEED_W-1:0]   min_speed_cms;
	logic [SPEED_W-1:0]   avg_speed_cms;
	logic                 stats_valid;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIST_W-1:0]    cfg_data;

	int          errors;
	int          pending;
	int unsigned words_sent = 0;
	int unsigned tick_pct = 50;
	int unsigned block_now = RST_BLOCK_SECONDS;
	bit          feed_calm = 1'b0;

	always #1 clk = ~clk;

	light_gate_speed_trap_unit i_dut (.*);

	light_gate_speed_trap_unit_checker i_checker (.*);

	// idle length per word, with runs of back-to-back words
	function automatic int unsigned pick_wait(inout bit calm);
		if ($urandom_range(0, 24) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 14);
	endfunction

	// one input word, held until accepted
	task automatic send_word(input logic f, input logic b1, input logic b2, input logic tick);
		int unsigned gap;
		gap = pick_wait(feed_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		beam1_lit   <= b1;
		beam2_lit   <= b2;
		second_tick <= tick;
		do @(posedge clk); while (in_ready !== 1'b1);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic gate_sample(input logic b1, input logic b2);
		send_word(1'b0, b1, b2, $urandom_range(0, 99) < tick_pct);
	endtask

	// break one beam, linger, then clear it; the other beam only matters on the break
	task automatic cross_beam(input bit right_beam);
		int unsigned linger;
		linger = $urandom_range(0, 2);
		if (right_beam)
			gate_sample(1'b1, 1'b0);
		else
			gate_sample(1'b0, 1'($urandom_range(0, 1)));
		repeat (linger) begin
			if (right_beam)
				gate_sample(1'($urandom_range(0, 1)), 1'b0);
			else
				gate_sample(1'b0, 1'($urandom_range(0, 1)));
		end
		if (right_beam)
			gate_sample(1'($urandom_range(0, 1)), 1'b1);
		else
			gate_sample(1'b1, 1'($urandom_range(0, 1)));
	endtask

	// a walker enters, stays a while, and leaves by the far beam or backs out
	task automatic walk(input bit leftward, input bit backout);
		int unsigned dwell;
		bit          linger_long;
		tick_pct    = $urandom_range(0, 100);
		linger_long = $urandom_range(0, 11) == 0;
		dwell = linger_long ? $urandom_range(1, (block_now > 60) ? 63 : block_now + 3)
			: $urandom_range(0, 4);
		cross_beam(leftward);
		repeat (dwell) begin
			if (linger_long)
				send_word(1'b0, 1'b1, 1'b1, 1'b1);
			else
				gate_sample(1'b1, 1'b1);
		end
		cross_beam(backout ? leftward : !leftward);
	endtask

	// register writes back to back, valid dropped after the last one
	task automatic write_regs(input logic [15:0] gate_dist, input logic [7:0] lim,
			input logic [7:0] blk, input bit spare);
		logic [CFG_IDX_W-1:0] idx[4];
		logic [DIST_W-1:0]    dat[4];
		int                   n;
		idx[0] = REG_GATE_DISTANCE;
		dat[0] = gate_dist;
		idx[1] = REG_SPEED_LIMIT;
		dat[1] = {8'($urandom), lim};
		idx[2] = REG_BLOCK_SECONDS;
		dat[2] = {8'($urandom), blk};
		idx[3] = 2'd3;
		dat[3] = 16'($urandom);
		n = spare ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= dat[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		block_now = blk;
	endtask

	// let every result out, then give words without results time to finish
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (48) @(negedge clk);
	endtask

	// result side: random stalls and one long hold-off
	initial begin : result_sink
		int unsigned hold;
		int unsigned taken;
		bit          calm;
		out_ready = 1'b0;
		taken = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = (taken == 25) ? 500 : pick_wait(calm);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			taken++;
			@(negedge clk);
		end
	end

	// no handshake of any kind for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned pick;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = 1'b0;
		beam1_lit   = 1'b1;
		beam2_lit   = 1'b1;
		second_tick = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_GATE_DISTANCE;
		cfg_data    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// report of an empty session
		send_word(1'b1, 1'b1, 1'b1, 1'b0);
		// both broken when idle, beam1 enters; both broken while moving backs out
		send_word(1'b0, 1'b0, 1'b0, 1'b0);
		send_word(1'b0, 1'b1, 1'b0, 1'b1);
		send_word(1'b0, 1'b1, 1'b1, 1'b1);
		send_word(1'b0, 1'b0, 1'b0, 1'b0);
		send_word(1'b0, 1'b1, 1'b1, 1'b0);
		// timed pass to the right, beam1 ignored while waiting at the exit
		send_word(1'b0, 1'b0, 1'b1, 1'b0);
		send_word(1'b0, 1'b1, 1'b1, 1'b0);
		send_word(1'b0, 1'b1, 1'b1, 1'b1);
		send_word(1'b0, 1'b1, 1'b0, 1'b0);
		send_word(1'b0, 1'b0, 1'b0, 1'b1);
		send_word(1'b0, 1'b0, 1'b1, 1'b1);
		// pass to the left with no second in between: too fast
		send_word(1'b0, 1'b1, 1'b0, 1'b0);
		send_word(1'b0, 1'b1, 1'b1, 1'b1);
		send_word(1'b0, 1'b0, 1'b1, 1'b0);
		send_word(1'b0, 1'b1, 1'b1, 1'b0);
		// long stay in the hall raises the blocking warning once
		send_word(1'b0, 1'b0, 1'b1, 1'b0);
		send_word(1'b0, 1'b1, 1'b1, 1'b0);
		repeat (13) send_word(1'b0, 1'b1, 1'b1, 1'b1);
		send_word(1'b0, 1'b1, 1'b0, 1'b1);
		send_word(1'b0, 1'b1, 1'b1, 1'b0);
		// report with passes, beams ignored
		send_word(1'b1, 1'b0, 1'b0, 1'b1);
		quiesce();

		for (int unsigned phase = 0; phase < 8; phase++) begin
			case (phase)
				0: ;
				1: write_regs(16'hFFFF, 8'hFF, 8'd0, 1'b0);
				2: write_regs(16'd1, 8'd0, 8'hFF, 1'b0);
				3: write_regs(16'd0, 8'($urandom_range(0, 9)), 8'($urandom_range(0, 20)), 1'b0);
				default: write_regs($urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
					: 16'($urandom_range(1, 1000)), 8'($urandom),
					8'($urandom_range(0, 30)), phase == 4);
			endcase
			while (words_sent < 35 + 115 * (phase + 1)) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					walk(1'($urandom_range(0, 1)), 1'b0);
				end else if (pick < 80) begin
					walk(1'($urandom_range(0, 1)), 1'b1);
				end else if (pick < 90) begin
					// unshaped words, now and then a report
					repeat ($urandom_range(1, 4))
						send_word($urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else if (pick < 95) begin
					// walker enters and the sequence is abandoned
					tick_pct = $urandom_range(0, 100);
					cross_beam(1'($urandom_range(0, 1)));
				end else begin
					send_word(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end
			end
			send_word(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			quiesce();
		end

		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lgst_pkg.sv
rtl/core/lgst_div.sv
rtl/core/light_gate_speed_trap_unit.sv
rtl/core/lgst_checker.sv
dv/light_gate_speed_trap_unit_checker.sv
dv/light_gate_speed_trap_unit_tb.sv
